// ===== src/text_alpha_invert_fade_defines.svh =====
// assertion macros shared by the text alpha invert and fade block
`ifndef TEXT_ALPHA_INVERT_FADE_DEFINES_SVH
`define TEXT_ALPHA_INVERT_FADE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TAF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define TAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/taf_pkg.sv =====
// types, codes and helper functions of the text alpha invert and fade block
`default_nettype none

package taf_pkg;

   localparam int PIXEL_W      = 32;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 18;
   localparam int REGION_MIN   = 2;
   localparam int REGION_RESET = 131072;

   // quotient bits of one fade division and steps of the shared divider
   localparam int Q_BITS    = 6;
   localparam int QIDX_W    = 3;
   localparam int DIV_STEPS = 2 * Q_BITS;
   localparam int STEP_W    = 4;

   localparam logic [PIXEL_W-1:0] ALPHA8_MASK = 32'hff00_0000;
   localparam logic [15:0]        ALPHA4_MASK = 16'hf000;

   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GENTLE_FALLOFF = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BYTES   = 2'd2;

   typedef enum logic [1:0] {
      FMT_ARGB8888    = 2'd0,
      FMT_ARGB1555    = 2'd1,
      FMT_ARGB4444    = 2'd2,
      FMT_UNSUPPORTED = 2'd3
   } taf_fmt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_PUSH
   } taf_state_type;

   typedef struct packed {
      logic              capture;
      logic              prep;
      logic              div_step;
      logic              div_first;
      logic              div_green;
      logic [QIDX_W-1:0] div_bit;
      logic              push;
   } taf_cmd_type;

   typedef struct packed {
      logic needs_div;
      logic out_free;
   } taf_sts_type;

   // floor(q / 3) for q below 64
   function automatic logic [Q_BITS-1:0] taf_div3(input logic [Q_BITS-1:0] q);
      logic [12:0] prod;
      prod = q * 7'd43;
      return prod[12:7];
   endfunction

   // second stage of the fade: quarter, third or half of the quotient
   function automatic logic [Q_BITS-1:0] taf_fade_dec(input logic [Q_BITS-1:0] q,
                                                      input logic gentle,
                                                      input logic red_dom);
      logic [Q_BITS-1:0] dec;
      if (gentle) begin
         dec = q >> 2;
      end else if (red_dom) begin
         dec = taf_div3(q);
      end else begin
         dec = q >> 1;
      end
      return dec;
   endfunction

endpackage

`default_nettype wire

// ===== src/taf_req_if.sv =====
// request channel carrying one input pixel
`default_nettype none

interface taf_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

// ===== src/taf_rsp_if.sv =====
// response channel carrying one processed pixel and its flags
`default_nettype none

interface taf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_out;
   logic        region_last;
   logic        format_error;

   modport source (output valid, output pixel_out, output region_last,
                   output format_error, input ready);
   modport sink (input valid, input pixel_out, input region_last,
                 input format_error, output ready);
endinterface

`default_nettype wire

// ===== src/taf_ctrl.sv =====
// controller state machine sequencing capture, divide and hand-off
`default_nettype none

module taf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire taf_pkg::taf_sts_type sts,
   output taf_pkg::taf_cmd_type      cmd
);
   import taf_pkg::*;

   taf_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] bit_full;
   logic              green;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign green    = (step_ff >= STEP_W'(Q_BITS));
   assign bit_full = green ? (STEP_W'(DIV_STEPS - 1) - step_ff)
                           : (STEP_W'(Q_BITS - 1) - step_ff);

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
            state_in = sts.needs_div ? ST_DIV : ST_PUSH;
         end
         ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_green = green;
            cmd.div_first = (step_ff == '0) || (step_ff == STEP_W'(Q_BITS));
            cmd.div_bit   = bit_full[QIDX_W-1:0];
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (sts.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/taf_datapath.sv =====
// datapath: byte offset, fade products, shared restoring divider, output register
`default_nettype none

module taf_datapath #(
   parameter int MAX_REGION_BYTES = 131072,
   localparam int R_W = $clog2(MAX_REGION_BYTES + 1),
   localparam int P_W = $clog2(MAX_REGION_BYTES)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire taf_pkg::taf_cmd_type cmd,
   output taf_pkg::taf_sts_type      sts,
   input  wire logic [31:0]          req_pixel,
   input  wire taf_pkg::taf_fmt_type fmt,
   input  wire logic                 gentle,
   input  wire logic [R_W-1:0]       region,
   taf_rsp_if.source                 rsp
);
   import taf_pkg::*;

   localparam int DW = R_W + Q_BITS;

   logic [PIXEL_W-1:0] pix_ff;
   logic [P_W-1:0]     pos_ff;
   logic [P_W-1:0]     off_ff;
   logic [DW-1:0]      prod_dom_ff, prod_grn_ff;
   logic [DW-1:0]      rem_ff, rem_in;
   logic [Q_BITS-1:0]  q_ff, q_in, q_dom_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff;
   logic               rsp_last_ff, rsp_err_ff;

   logic [4:0]         red, grn, blu, dom_c;
   logic               red_dom, dbl;
   logic [P_W+4:0]     mul_dom, mul_grn;
   logic [P_W+5:0]     sh_dom, sh_grn;
   logic [DW-1:0]      rem_cur, divisor;
   logic               ge;
   logic [Q_BITS-1:0]  dec_dom, dec_grn;
   logic [5:0]         new_dom, new_grn;
   logic [PIXEL_W-1:0] faded, result;
   logic [2:0]         step, span;
   logic [R_W:0]       end_sum;
   logic [P_W:0]       adv;
   logic               last, is_unsup;

   assign red     = pix_ff[14:10];
   assign grn     = pix_ff[9:5];
   assign blu     = pix_ff[4:0];
   assign red_dom = (red >= blu);
   assign dom_c   = red_dom ? red : blu;
   assign dbl     = !gentle && red_dom;

   assign mul_dom = dom_c * off_ff;
   assign mul_grn = grn * off_ff;
   assign sh_dom  = dbl ? {mul_dom, 1'b0} : {1'b0, mul_dom};
   assign sh_grn  = dbl ? {mul_grn, 1'b0} : {1'b0, mul_grn};

   // one restoring step per cycle, quotient known to stay below 64
   assign rem_cur = cmd.div_first ? (cmd.div_green ? prod_grn_ff : prod_dom_ff) : rem_ff;
   assign divisor = DW'(region) << cmd.div_bit;
   assign ge      = (rem_cur >= divisor);
   assign rem_in  = ge ? (rem_cur - divisor) : rem_cur;

   always_comb begin
      q_in = cmd.div_first ? '0 : q_ff;
      q_in[cmd.div_bit] = ge;
   end

   // the fade never takes more than the channel holds
   assign dec_dom = taf_fade_dec(q_dom_ff, gentle, red_dom);
   assign dec_grn = taf_fade_dec(q_ff, gentle, red_dom);
   assign new_dom = {1'b0, dom_c} - dec_dom;
   assign new_grn = {1'b0, grn} - dec_grn;
   assign faded   = {16'h0000, 1'b1, red_dom ? new_dom[4:0] : red, new_grn[4:0],
                     red_dom ? blu : new_dom[4:0]};

   always_comb begin
      is_unsup = 1'b0;
      case (fmt)
         FMT_ARGB8888: begin
            result = pix_ff ^ ALPHA8_MASK;
            step   = 3'd4;
            span   = 3'd7;
         end
         FMT_ARGB4444: begin
            result = {16'h0000, pix_ff[15:0] ^ ALPHA4_MASK};
            step   = 3'd2;
            span   = 3'd3;
         end
         FMT_ARGB1555: begin
            result = pix_ff[15] ? '0 : faded;
            step   = 3'd2;
            span   = 3'd2;
         end
         default: begin
            result   = pix_ff;
            step     = 3'd0;
            span     = 3'd0;
            is_unsup = 1'b1;
         end
      endcase
   end

   assign end_sum = (R_W + 1)'(off_ff) + (R_W + 1)'(span);
   assign last    = (end_sum >= (R_W + 1)'(region));
   assign adv     = (P_W + 1)'(off_ff) + (P_W + 1)'(step);

   assign sts.needs_div = (fmt == FMT_ARGB1555) && !pix_ff[15];
   assign sts.out_free  = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.push && !is_unsup) begin
            pos_ff <= last ? '0 : adv[P_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pix_ff <= req_pixel;
         off_ff <= (R_W'(pos_ff) < region) ? pos_ff : '0;
      end
      if (cmd.prep) begin
         prod_dom_ff <= DW'(sh_dom);
         prod_grn_ff <= DW'(sh_grn);
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         if (cmd.div_first && cmd.div_green) begin
            q_dom_ff <= q_ff;
         end
      end
      if (cmd.push) begin
         rsp_pixel_ff <= result;
         rsp_last_ff  <= last && !is_unsup;
         rsp_err_ff   <= is_unsup;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pixel_out    = rsp_pixel_ff;
   assign rsp.region_last  = rsp_last_ff;
   assign rsp.format_error = rsp_err_ff;

endmodule

`default_nettype wire

// ===== src/text_alpha_invert_fade.sv =====
// top level: configuration registers, controller and datapath
//
//   channel   direction  handshake        payload
//   req_chan  in         valid / ready    pixel_in[31:0]
//   rsp_chan  out        valid / ready    pixel_out[31:0], region_last, format_error
//   csr_*     in         csr_wr_en only   csr_index[1:0], csr_wr_data[17:0]
//
// a request passes capture, prep and hand-off before the next acceptance, and the divider too
// for an ARGB1555 pixel with its alpha bit clear: it runs 6 steps for each of two channels.
// reset is synchronous, clears the byte offset and the controller and sets the configuration to its defaults.
// a finished result waits in the output register; the next request is taken meanwhile,
// and only its hand-off waits until the held result is taken.
`default_nettype none
`include "text_alpha_invert_fade_defines.svh"

module text_alpha_invert_fade #(
   parameter int MAX_REGION_BYTES = 131072
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   taf_req_if.sink                               req_chan,
   taf_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_wr_en,
   input  wire logic [taf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [taf_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import taf_pkg::*;

   localparam int R_W        = $clog2(MAX_REGION_BYTES + 1);
   localparam int REGION_RST = (REGION_RESET > MAX_REGION_BYTES) ? MAX_REGION_BYTES
                                                                 : REGION_RESET;

   taf_fmt_type  fmt_ff;
   logic         gentle_ff;
   logic [R_W-1:0] region_ff, region_wr;
   taf_cmd_type  cmd;
   taf_sts_type  sts;
   logic         req_ready;

   // region size is clamped when written
   always_comb begin
      if (csr_wr_data < CSR_DATA_W'(REGION_MIN)) begin
         region_wr = R_W'(REGION_MIN);
      end else if (32'(csr_wr_data) > 32'(MAX_REGION_BYTES)) begin
         region_wr = R_W'(MAX_REGION_BYTES);
      end else begin
         region_wr = R_W'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_ARGB1555;
         gentle_ff <= 1'b0;
         region_ff <= R_W'(REGION_RST);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PIXEL_FORMAT:   fmt_ff    <= taf_fmt_type'(csr_wr_data[1:0]);
            CSR_GENTLE_FALLOFF: gentle_ff <= csr_wr_data[0];
            CSR_REGION_BYTES:   region_ff <= region_wr;
            default: begin
            end
         endcase
      end
   end

   assign req_chan.ready = req_ready;

   taf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   taf_datapath #(
      .MAX_REGION_BYTES (MAX_REGION_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_pixel (req_chan.pixel_in),
      .fmt       (fmt_ff),
      .gentle    (gentle_ff),
      .region    (region_ff),
      .rsp       (rsp_chan)
   );

   `TAF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_chan.valid && req_ready, !req_ready, "request taken while busy")
   `TAF_ASSERT_SAME(a_push_when_free, clock, reset, cmd.push, sts.out_free, "result overwrote a held result")
   `TAF_ASSERT_SAME(a_err_not_last, clock, reset, rsp_chan.valid && rsp_chan.format_error, !rsp_chan.region_last, "format error flagged as region end")

endmodule

`default_nettype wire
